// ===== src/mfh_pkg.sv =====
package mfh_pkg;

  localparam int unsigned LenWidth   = 28;
  localparam int unsigned GroupWidth = 7;
  localparam int unsigned LenBytes   = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  // One byte of the packet buffer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  // One decoded fixed header
  typedef struct packed {
    status_t               status;
    logic [3:0]            message_type;
    logic                  duplicate;
    logic [1:0]            qos;
    logic                  retain_flag;
    logic [LenWidth-1:0]   remaining_length;
    logic [2:0]            header_bytes;
  } header_item_t;

endpackage

// ===== src/mfh_if.sv =====
interface mfh_byte_if import mfh_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface mfh_header_if import mfh_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [3:0]          message_type;
  logic                duplicate;
  logic [1:0]          qos;
  logic                retain_flag;
  logic [LenWidth-1:0] remaining_length;
  logic [2:0]          header_bytes;

  modport source (
    output valid, output status, output message_type, output duplicate,
    output qos, output retain_flag, output remaining_length,
    output header_bytes, input ready
  );
  modport sink (
    input valid, input status, input message_type, input duplicate,
    input qos, input retain_flag, input remaining_length,
    input header_bytes, output ready
  );
endinterface

// ===== src/mfh_in_reg.sv =====
module mfh_in_reg import mfh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  input  logic       advance,
  output logic       stage_valid,
  output byte_item_t stage_item
);

  // Take a new item whenever the stage is empty or moves on this cycle
  assign in_ready = !stage_valid || advance;

  // Hold the valid flag of the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

// ===== src/mfh_decode.sv =====
module mfh_decode import mfh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  byte_item_t   item,
  output logic         emit,
  output header_item_t result
);

  logic [2:0]          byte_position;
  logic [2:0]          byte_position_next;
  logic [LenWidth-1:0] length_accumulator;
  logic [LenWidth-1:0] length_accumulator_next;
  logic [7:0]          first_byte;
  logic [7:0]          first_byte_next;
  logic                result_given;
  logic                result_given_next;
  logic [7:0]          ctrl_byte;
  logic [4:0]          group_shift;
  logic [LenWidth-1:0] group_value;
  status_t             status;
  logic [LenWidth-1:0] out_length;
  logic [2:0]          out_header;

  // Place the seven length bits by the position of the byte
  always_comb begin
    case (byte_position)
      3'd2:    group_shift = 5'd7;
      3'd3:    group_shift = 5'd14;
      3'd4:    group_shift = 5'd21;
      default: group_shift = 5'd0;
    endcase
  end

  assign group_value = LenWidth'(item.data_byte[GroupWidth-1:0]) << group_shift;
  assign ctrl_byte   = (byte_position == 3'd0) ? item.data_byte : first_byte;

  // Work out the next state and whether this byte settles the header
  always_comb begin
    byte_position_next      = byte_position;
    length_accumulator_next = length_accumulator;
    first_byte_next         = first_byte;
    result_given_next       = result_given;
    emit                    = 1'b0;
    status                  = ST_OK;
    out_length              = '0;
    out_header              = '0;
    if (!result_given) begin
      if (byte_position == 3'd0) begin
        first_byte_next    = item.data_byte;
        byte_position_next = 3'd1;
        if (item.end_of_buffer) begin
          emit   = 1'b1;
          status = ST_TRUNC;
        end
      end else if (byte_position <= 3'(LenBytes)) begin
        length_accumulator_next = length_accumulator | group_value;
        byte_position_next      = byte_position + 3'd1;
        if (!item.data_byte[7]) begin
          emit       = 1'b1;
          status     = ST_OK;
          out_length = length_accumulator | group_value;
          out_header = byte_position + 3'd1;
        end else if (item.end_of_buffer) begin
          emit   = 1'b1;
          status = ST_TRUNC;
        end
      end else begin
        emit   = 1'b1;
        status = ST_LONG;
      end
      if (emit) begin
        result_given_next = 1'b1;
      end
    end
    // Restart at the end of the buffer
    if (item.end_of_buffer) begin
      byte_position_next      = '0;
      length_accumulator_next = '0;
      first_byte_next         = '0;
      result_given_next       = 1'b0;
    end
  end

  // Pack the result
  always_comb begin
    result.status           = status;
    result.message_type     = ctrl_byte[7:4];
    result.duplicate        = ctrl_byte[3];
    result.qos              = ctrl_byte[2:1];
    result.retain_flag      = ctrl_byte[0];
    result.remaining_length = out_length;
    result.header_bytes     = out_header;
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      length_accumulator <= '0;
      first_byte         <= '0;
      result_given       <= 1'b0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      length_accumulator <= length_accumulator_next;
      first_byte         <= first_byte_next;
      result_given       <= result_given_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= 3'(LenBytes + 1))
    else $error("byte position past the too-long point");

  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && status == ST_OK) |->
      (out_header >= 3'd2 && out_header <= 3'(LenBytes + 1)))
    else $error("header length out of range on a complete header");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && item.end_of_buffer) |=> (byte_position == 3'd0 && !result_given))
    else $error("parser did not restart after the last byte");

  a_single: assert property (@(posedge clk) disable iff (rst)
    (advance && result_given) |-> !emit)
    else $error("second header result for one buffer");
`endif

endmodule

// ===== src/mfh_out_reg.sv =====
module mfh_out_reg import mfh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  header_item_t load_item,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output header_item_t out_item
);

  // Free when empty or when the waiting item leaves this cycle
  assign can_take = !out_valid || out_ready;

  // Hold the valid flag until the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load && can_take) begin
      out_item <= load_item;
    end
  end

endmodule

// ===== src/mqtt_fixed_header_parser.sv =====
// MQTT fixed header parser. Bytes of one packet buffer arrive on the bytes
// channel, one per item, the last one marked by end_of_buffer. The block
// takes one byte per clock cycle while the header channel does not stall it,
// and gives one header item per buffer: status ok with type, flags,
// remaining length and header length (2 to 5) at the length byte whose
// continuation bit is clear; status truncated when the buffer ends before
// that; status too long at a sixth byte after four continued length bytes.
// Bytes after the result are dropped up to end_of_buffer, which restarts the
// parser. A taken byte is held in the input register, and the combinational
// decode logic loads the result register from it once that register is free.
// Backpressure from the header channel stalls the byte channel only once the
// result register holds an untaken item.
module mqtt_fixed_header_parser import mfh_pkg::*; (
  input logic          clk,
  input logic          rst,
  mfh_byte_if.sink     bytes,
  mfh_header_if.source result
);

  byte_item_t   in_item;
  byte_item_t   stage_item;
  logic         stage_valid;
  logic         advance;
  logic         out_can_take;
  logic         emit;
  header_item_t dec_item;
  header_item_t out_item;

  assign in_item.data_byte     = bytes.data_byte;
  assign in_item.end_of_buffer = bytes.end_of_buffer;

  // Move the staged byte through decode when the result register is free
  assign advance = stage_valid && out_can_take;

  mfh_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (bytes.valid),
    .in_ready    (bytes.ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  mfh_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .emit    (emit),
    .result  (dec_item)
  );

  mfh_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_item (dec_item),
    .can_take  (out_can_take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_item  (out_item)
  );

  assign result.status           = out_item.status;
  assign result.message_type     = out_item.message_type;
  assign result.duplicate        = out_item.duplicate;
  assign result.qos              = out_item.qos;
  assign result.retain_flag      = out_item.retain_flag;
  assign result.remaining_length = out_item.remaining_length;
  assign result.header_bytes     = out_item.header_bytes;

endmodule
